### design/spz_pkg.sv
// ----------------------------------------------------------------------------
// spz_pkg
// Shared types and constants for the Spritz sponge engine.
// ----------------------------------------------------------------------------
package spz_pkg;

    localparam int unsigned SBOX_DEPTH = 256;
    localparam int unsigned ADDR_W     = 8;
    localparam int unsigned BYTE_W     = 8;

    typedef logic [ADDR_W-1:0] sbox_addr_t;
    typedef logic [BYTE_W-1:0] byte_t;

    typedef enum logic [2:0] {
        CMD_INIT   = 3'd0,
        CMD_ABSORB = 3'd1,
        CMD_STOP   = 3'd2,
        CMD_DRIP   = 3'd3,
        CMD_XOR    = 3'd4
    } cmd_t;

    // Nibbles pending before a shuffle is forced.
    localparam byte_t HALF_COUNT = 8'd128;
    localparam byte_t NIB_BASE   = 8'd128;
    localparam byte_t LAST_CRUSH = 8'd127;

    typedef struct packed {
        logic       wr_en;
        sbox_addr_t wr_addr;
        byte_t      wr_data;
        sbox_addr_t rd_addr;
    } sbox_req_t;

endpackage

### design/spz_sbox_ram.sv
// ----------------------------------------------------------------------------
// spz_sbox_ram
// Permutation store: one write port and one registered read port.
// ----------------------------------------------------------------------------
module spz_sbox_ram
    import spz_pkg::*;
(
    input  logic      aclk,
    input  sbox_req_t req,
    output byte_t     rd_data
);

    byte_t mem [SBOX_DEPTH];
    byte_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        rd_data_reg <= mem[req.rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### design/spritz_sponge_cipher_engine.sv
// ----------------------------------------------------------------------------
// spritz_sponge_cipher_engine
// Spritz sponge (N = 256) run one command per transaction.
// ----------------------------------------------------------------------------
// Channel  | Ports                     | Contents
// input    | s_tvalid s_tready s_tdata | [2:0] cmd, [10:3] data_byte
// result   | m_tvalid m_tready m_tdata | [7:0] result_byte
//
// A permutation update walks states UPD_A to UPD_E through the S-box memory;
// drip and xor run one update and then the output states; an absorbed byte swaps once per nibble.
// A shuffle runs 3 x 512 updates plus 2 x 128 compare-and-swap steps.
// After reset, and after init, a sweep over all 256 entries rewrites the identity
// permutation with s_tready low. A held result does not block the next
// transaction until its own result is ready.
// ----------------------------------------------------------------------------
module spritz_sponge_cipher_engine
    import spz_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // cmd [2:0], data_byte [10:3], zero [15:11]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // result_byte [7:0]
);

    typedef enum logic [4:0] {
        ST_FILL, ST_IDLE, ST_ABS,
        ST_UPD_A, ST_UPD_B, ST_UPD_C, ST_UPD_D, ST_UPD_E,
        ST_SW_A, ST_SW_B, ST_SW_C, ST_SW_D,
        ST_OUT_A, ST_OUT_B, ST_OUT_C, ST_OUT_D, ST_OUT_W
    } state_t;

    typedef enum logic [1:0] { POST_ABS, POST_STOP, POST_KEY } post_t;

    state_t     state_reg, state_next;
    post_t      post_reg, post_next;
    byte_t      i_reg, i_next, j_reg, j_next, k_reg, k_next, z_reg, z_next;
    byte_t      a_reg, a_next, w_reg, w_next, tmp_reg, tmp_next;
    byte_t      p_reg, p_next, q_reg, q_next, fill_reg, fill_next;
    logic [8:0] upd_cnt_reg, upd_cnt_next;
    logic [1:0] whip_reg, whip_next;
    logic       shuf_reg, shuf_next, crush_reg, crush_next;
    logic       hi_reg, hi_next, swap_reg, swap_next;
    cmd_t       cmd_reg, cmd_next;
    byte_t      byte_reg, byte_next;
    logic       m_valid_reg, m_valid_next;
    byte_t      m_data_reg, m_data_next;
    sbox_req_t  req;
    byte_t      rd;

    spz_sbox_ram u_sbox (.aclk(aclk), .req(req), .rd_data(rd));

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_comb begin
        state_next   = state_reg;   post_next  = post_reg;
        i_next       = i_reg;       j_next     = j_reg;
        k_next       = k_reg;       z_next     = z_reg;
        a_next       = a_reg;       w_next     = w_reg;
        tmp_next     = tmp_reg;     p_next     = p_reg;
        q_next       = q_reg;       fill_next  = fill_reg;
        upd_cnt_next = upd_cnt_reg; whip_next  = whip_reg;
        shuf_next    = shuf_reg;    crush_next = crush_reg;
        hi_next      = hi_reg;      swap_next  = swap_reg;
        cmd_next     = cmd_reg;     byte_next  = byte_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_tready;
        req          = '0;

        case (state_reg)
            ST_FILL: begin
                req.wr_en   = 1'b1;
                req.wr_addr = fill_reg;
                req.wr_data = fill_reg;
                fill_next   = fill_reg + 8'd1;
                if (fill_reg == 8'hff) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd_next  = cmd_t'(s_tdata[2:0]);
                    byte_next = s_tdata[10:3];
                    hi_next   = 1'b0;
                    case (s_tdata[2:0])
                        CMD_INIT: begin
                            i_next = '0; j_next = '0; k_next = '0; z_next = '0;
                            a_next = '0; w_next = 8'd1; fill_next = '0;
                            state_next = ST_FILL;
                        end
                        CMD_ABSORB: state_next = ST_ABS;
                        CMD_STOP: begin
                            if (a_reg == HALF_COUNT) begin
                                post_next = POST_STOP; shuf_next = 1'b1;
                                upd_cnt_next = '0; whip_next = '0;
                                state_next = ST_UPD_A;
                            end else begin
                                a_next = a_reg + 8'd1;
                            end
                        end
                        CMD_DRIP, CMD_XOR: begin
                            post_next = POST_KEY; upd_cnt_next = '0; whip_next = '0;
                            shuf_next = (a_reg != 8'd0);
                            state_next = ST_UPD_A;
                        end
                        default: ;
                    endcase
                end
            end
            ST_ABS: begin
                if (a_reg == HALF_COUNT) begin
                    post_next = POST_ABS; shuf_next = 1'b1;
                    upd_cnt_next = '0; whip_next = '0;
                    state_next = ST_UPD_A;
                end else begin
                    p_next = a_reg;
                    q_next = NIB_BASE + {4'd0, hi_reg ? byte_reg[7:4] : byte_reg[3:0]};
                    crush_next = 1'b0;
                    state_next = ST_SW_A;
                end
            end
            ST_UPD_A: begin
                i_next      = i_reg + w_reg;
                req.rd_addr = i_reg + w_reg;
                state_next  = ST_UPD_B;
            end
            ST_UPD_B: begin
                tmp_next    = rd;
                req.rd_addr = j_reg + rd;
                state_next  = ST_UPD_C;
            end
            ST_UPD_C: begin
                j_next      = k_reg + rd;
                req.rd_addr = k_reg + rd;
                state_next  = ST_UPD_D;
            end
            ST_UPD_D: begin
                k_next      = i_reg + k_reg + rd;
                req.wr_en   = 1'b1;
                req.wr_addr = i_reg;
                req.wr_data = rd;
                state_next  = ST_UPD_E;
            end
            ST_UPD_E: begin
                req.wr_en   = 1'b1;
                req.wr_addr = j_reg;
                req.wr_data = tmp_reg;
                if (!shuf_reg) begin
                    state_next = ST_OUT_A;
                end else begin
                    upd_cnt_next = upd_cnt_reg + 9'd1;
                    state_next   = ST_UPD_A;
                    if (upd_cnt_reg == 9'h1ff) begin
                        w_next = w_reg + 8'd2;
                        if (whip_reg == 2'd2) begin
                            // Shuffle complete: resume the command that asked for it.
                            a_next    = '0;
                            shuf_next = 1'b0;
                            case (post_reg)
                                POST_ABS:  state_next = ST_ABS;
                                POST_STOP: begin
                                    a_next = 8'd1; state_next = ST_IDLE;
                                end
                                default:   state_next = ST_UPD_A;
                            endcase
                        end else begin
                            p_next = '0; q_next = 8'hff; crush_next = 1'b1;
                            state_next = ST_SW_A;
                        end
                    end
                end
            end
            ST_SW_A: begin
                req.rd_addr = p_reg;
                state_next  = ST_SW_B;
            end
            ST_SW_B: begin
                tmp_next    = rd;
                req.rd_addr = q_reg;
                state_next  = ST_SW_C;
            end
            ST_SW_C: begin
                swap_next   = !crush_reg || (tmp_reg > rd);
                req.wr_en   = !crush_reg || (tmp_reg > rd);
                req.wr_addr = p_reg;
                req.wr_data = rd;
                state_next  = ST_SW_D;
            end
            ST_SW_D: begin
                req.wr_en   = swap_reg;
                req.wr_addr = q_reg;
                req.wr_data = tmp_reg;
                if (crush_reg) begin
                    p_next = p_reg + 8'd1;
                    q_next = q_reg - 8'd1;
                    state_next = ST_SW_A;
                    if (p_reg == LAST_CRUSH) begin
                        whip_next = whip_reg + 2'd1;
                        upd_cnt_next = '0;
                        state_next = ST_UPD_A;
                    end
                end else begin
                    a_next  = a_reg + 8'd1;
                    hi_next = 1'b1;
                    state_next = hi_reg ? ST_IDLE : ST_ABS;
                end
            end
            ST_OUT_A: begin
                req.rd_addr = z_reg + k_reg;
                state_next  = ST_OUT_B;
            end
            ST_OUT_B: begin
                req.rd_addr = i_reg + rd;
                state_next  = ST_OUT_C;
            end
            ST_OUT_C: begin
                req.rd_addr = j_reg + rd;
                state_next  = ST_OUT_D;
            end
            ST_OUT_D: begin
                z_next     = rd;
                state_next = ST_OUT_W;
            end
            ST_OUT_W: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = (cmd_reg == CMD_XOR) ? (z_reg ^ byte_reg) : z_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_FILL;  fill_reg <= '0;
            i_reg <= '0; j_reg <= '0; k_reg <= '0; z_reg <= '0;
            a_reg <= '0; w_reg <= 8'd1;
            shuf_reg <= 1'b0; crush_reg <= 1'b0; hi_reg <= 1'b0; swap_reg <= 1'b0;
            upd_cnt_reg <= '0; whip_reg <= '0; post_reg <= POST_ABS;
            cmd_reg <= CMD_INIT; m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;  fill_reg <= fill_next;
            i_reg <= i_next; j_reg <= j_next; k_reg <= k_next; z_reg <= z_next;
            a_reg <= a_next; w_reg <= w_next;
            shuf_reg <= shuf_next; crush_reg <= crush_next;
            hi_reg <= hi_next; swap_reg <= swap_next;
            upd_cnt_reg <= upd_cnt_next; whip_reg <= whip_next; post_reg <= post_next;
            cmd_reg <= cmd_next; m_valid_reg <= m_valid_next;
        end
        tmp_reg <= tmp_next; p_reg <= p_next; q_reg <= q_next;
        byte_reg <= byte_next; m_data_reg <= m_data_next;
    end

    a_pending_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        a_reg <= HALF_COUNT) else $error("pending nibble count above half size");
    a_step_odd: assert property (@(posedge aclk) disable iff (!aresetn)
        w_reg[0]) else $error("step became even");
    a_idle_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> !req.wr_en) else $error("S-box written while idle");
    a_crush_span: assert property (@(posedge aclk) disable iff (!aresetn)
        (crush_reg && state_reg == ST_SW_A) |-> (p_reg < NIB_BASE && q_reg == ~p_reg))
        else $error("crush pair out of range");

endmodule
